FILE: rtl/core/rcvs_pkg.sv
// ----------------------------------------------------------------------------
// rcvs_pkg
// Shared types, codes and the edge side classifier for the contour vertex shift.
// ----------------------------------------------------------------------------
package rcvs_pkg;

  // Sign of (to - from) along one axis
  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;

  // Side of an axis-aligned edge; SIDE_BAD for diagonal or zero length
  typedef enum logic [2:0] {
    SIDE_N   = 3'd0,
    SIDE_E   = 3'd1,
    SIDE_S   = 3'd2,
    SIDE_W   = 3'd3,
    SIDE_BAD = 3'd4
  } side_e;

  // Vertices seen in the open polygon
  typedef enum logic [1:0] {
    SEEN_NONE = 2'd0,
    SEEN_ONE  = 2'd1,
    SEEN_MANY = 2'd2
  } seen_e;

  // Output queue geometry: room for the three results of a closing vertex
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QCntW    = 3;
  localparam int unsigned MaxPush  = 3;
  localparam int unsigned PushCntW = 2;

  function automatic side_e edge_side(input cmp_e sx, input cmp_e sy, input logic outer);
    side_e s;
    s = SIDE_BAD;
    if (sx == CMP_EQ && sy == CMP_GT) begin
      s = outer ? SIDE_E : SIDE_W;
    end else if (sx == CMP_GT && sy == CMP_EQ) begin
      s = outer ? SIDE_N : SIDE_S;
    end else if (sx == CMP_EQ && sy == CMP_LT) begin
      s = outer ? SIDE_W : SIDE_E;
    end else if (sx == CMP_LT && sy == CMP_EQ) begin
      s = outer ? SIDE_S : SIDE_N;
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/raster_contour_vertex_shift_top.sv
// ----------------------------------------------------------------------------
// raster_contour_vertex_shift_top
// Shifts the vertices of a closed axis-aligned contour onto pixel edges.
// ----------------------------------------------------------------------------
// Vertices of one closed polygon stream in on the slave side, tlast on the
// final vertex. Each vertex comes out once on the master side with its x
// lowered by one if an adjacent edge is an East side and its y lowered by one
// for a South side (sides mirror when outer_contour is 0). A vertex's result
// leaves when its successor arrives; on the closing vertex of a polygon of
// three or more vertices three beats leave: the previous vertex, the closing
// vertex, and vertex 0 last, with tlast and the first-vertex flag set. A
// diagonal or zero-length neighbor edge sets the edge-error flag and the
// vertex passes unchanged. The input register feeds three correction units
// in parallel and results land in a four-entry queue. A beat is accepted
// every cycle unless the queue lacks room for three more beats; the three
// beats of a closing vertex stall the next push even when the master side
// drains one beat per cycle. Write outer_contour only while the block is
// idle.
// ----------------------------------------------------------------------------
module raster_contour_vertex_shift_top
  import rcvs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  // configuration: bit 0 is outer_contour
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [vertex_x, vertex_y] from bit 0, zero filled to bytes
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,   // last_vertex

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [shifted_x, shifted_y] from bit 0, zero filled to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,   // [is_first_vertex, edge_error]
  output logic                                 m_axis_tlast    // end_of_polygon
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned RW  = 2*COORD_BITS + 2;  // x, y, err, first

  typedef logic signed [CB-1:0] coord_t;

  // configuration
  logic outer_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= 1'b1;
    end else if (cfg_valid_i) begin
      outer_q <= cfg_data_i;
    end
  end

  // input register stage
  logic   in_vld_q;
  coord_t in_x_q, in_y_q;
  logic   in_last_q;
  logic   fire, room;

  assign s_axis_tready = !in_vld_q || fire;
  assign fire          = in_vld_q && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x_q    <= s_axis_tdata[CB-1:0];
      in_y_q    <= s_axis_tdata[2*CB-1:CB];
      in_last_q <= s_axis_tlast;
    end
  end

  // polygon tracking state
  seen_e  seen_q;
  coord_t start_x_q, start_y_q, second_x_q, second_y_q;
  coord_t before_x_q, before_y_q, held_x_q, held_y_q;
  coord_t before_x_n, before_y_n, second_x_n, second_y_n;
  logic   seen_none;

  assign seen_none  = (seen_q == SEEN_NONE);
  // predecessor of the current vertex once it is held
  assign before_x_n = (seen_q == SEEN_ONE) ? start_x_q : held_x_q;
  assign before_y_n = (seen_q == SEEN_ONE) ? start_y_q : held_y_q;
  assign second_x_n = (seen_q == SEEN_ONE) ? in_x_q : second_x_q;
  assign second_y_n = (seen_q == SEEN_ONE) ? in_y_q : second_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= SEEN_NONE;
      start_x_q  <= '0;
      start_y_q  <= '0;
      second_x_q <= '0;
      second_y_q <= '0;
      before_x_q <= '0;
      before_y_q <= '0;
      held_x_q   <= '0;
      held_y_q   <= '0;
    end else if (fire) begin
      if (seen_none) begin
        start_x_q <= in_x_q;
        start_y_q <= in_y_q;
        seen_q    <= in_last_q ? SEEN_NONE : SEEN_ONE;
      end else begin
        second_x_q <= second_x_n;
        second_y_q <= second_y_n;
        before_x_q <= before_x_n;
        before_y_q <= before_y_n;
        held_x_q   <= in_x_q;
        held_y_q   <= in_y_q;
        seen_q     <= in_last_q ? SEEN_NONE : SEEN_MANY;
      end
    end
  end

  // correction units
  // u0: held vertex (or a lone vertex), u1: closing vertex, u2: vertex 0
  coord_t u0_px, u0_py, u0_cx, u0_cy;
  coord_t u0_x, u0_y, u1_x, u1_y, u2_x, u2_y;
  logic   u0_err, u1_err, u2_err;

  assign u0_px = seen_none ? in_x_q : before_x_q;
  assign u0_py = seen_none ? in_y_q : before_y_q;
  assign u0_cx = seen_none ? in_x_q : held_x_q;
  assign u0_cy = seen_none ? in_y_q : held_y_q;

  rcvs_emit #(.CoordBits(CB)) u_emit_held (
    .prev_x_i (u0_px),      .prev_y_i (u0_py),
    .cur_x_i  (u0_cx),      .cur_y_i  (u0_cy),
    .next_x_i (in_x_q),     .next_y_i (in_y_q),
    .outer_i  (outer_q),
    .x_o      (u0_x),       .y_o      (u0_y),     .err_o (u0_err)
  );

  rcvs_emit #(.CoordBits(CB)) u_emit_close (
    .prev_x_i (before_x_n), .prev_y_i (before_y_n),
    .cur_x_i  (in_x_q),     .cur_y_i  (in_y_q),
    .next_x_i (start_x_q),  .next_y_i (start_y_q),
    .outer_i  (outer_q),
    .x_o      (u1_x),       .y_o      (u1_y),     .err_o (u1_err)
  );

  rcvs_emit #(.CoordBits(CB)) u_emit_first (
    .prev_x_i (in_x_q),     .prev_y_i (in_y_q),
    .cur_x_i  (start_x_q),  .cur_y_i  (start_y_q),
    .next_x_i (second_x_n), .next_y_i (second_y_n),
    .outer_i  (outer_q),
    .x_o      (u2_x),       .y_o      (u2_y),     .err_o (u2_err)
  );

  // beat layout: {first, err, y, x}
  logic [RW-1:0]       r0, r1, r2;
  logic [RW-1:0]       push_data [MaxPush];
  logic [PushCntW-1:0] push_cnt;
  logic                use_u0, use_close;

  assign r0 = {seen_none, u0_err, u0_y, u0_x};
  assign r1 = {1'b0, u1_err, u1_y, u1_x};
  assign r2 = {1'b1, u2_err, u2_y, u2_x};

  assign use_u0    = seen_none ? in_last_q : (seen_q == SEEN_MANY);
  assign use_close = !seen_none && in_last_q;

  always_comb begin
    push_data[0] = use_u0 ? r0 : r1;
    push_data[1] = use_u0 ? r1 : r2;
    push_data[2] = r2;
    push_cnt     = '0;
    if (fire) begin
      push_cnt = PushCntW'(use_u0) + (use_close ? PushCntW'(2) : PushCntW'(0));
    end
  end

  // output queue
  logic [RW-1:0] head;

  rcvs_queue #(.Width(RW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (head)
  );

  assign m_axis_tdata = DW'(head[2*CB-1:0]);
  assign m_axis_tuser = {head[2*CB], head[2*CB+1]};
  assign m_axis_tlast = head[2*CB+1];

endmodule

FILE: rtl/core/rcvs_emit.sv
// ----------------------------------------------------------------------------
// rcvs_emit
// Corrects one vertex from its predecessor and successor (combinational).
// ----------------------------------------------------------------------------
module rcvs_emit
  import rcvs_pkg::*;
#(
  parameter int unsigned CoordBits = 16
) (
  input  logic signed [CoordBits-1:0] prev_x_i,
  input  logic signed [CoordBits-1:0] prev_y_i,
  input  logic signed [CoordBits-1:0] cur_x_i,
  input  logic signed [CoordBits-1:0] cur_y_i,
  input  logic signed [CoordBits-1:0] next_x_i,
  input  logic signed [CoordBits-1:0] next_y_i,
  input  logic                        outer_i,
  output logic signed [CoordBits-1:0] x_o,
  output logic signed [CoordBits-1:0] y_o,
  output logic                        err_o
);

  function automatic cmp_e cmp(input logic signed [CoordBits-1:0] to_v,
                               input logic signed [CoordBits-1:0] from_v);
    cmp_e c;
    if (to_v > from_v) begin
      c = CMP_GT;
    end else if (to_v < from_v) begin
      c = CMP_LT;
    end else begin
      c = CMP_EQ;
    end
    return c;
  endfunction

  side_e in_side, out_side;
  logic  dec_x, dec_y;

  assign in_side  = edge_side(cmp(cur_x_i, prev_x_i), cmp(cur_y_i, prev_y_i), outer_i);
  assign out_side = edge_side(cmp(next_x_i, cur_x_i), cmp(next_y_i, cur_y_i), outer_i);
  assign err_o    = (in_side == SIDE_BAD) || (out_side == SIDE_BAD);

  // a side shared by both edges is applied once, so an OR is enough
  assign dec_x = !err_o && (in_side == SIDE_E || out_side == SIDE_E);
  assign dec_y = !err_o && (in_side == SIDE_S || out_side == SIDE_S);

  assign x_o = dec_x ? cur_x_i - CoordBits'(1) : cur_x_i;
  assign y_o = dec_y ? cur_y_i - CoordBits'(1) : cur_y_i;

endmodule

FILE: rtl/core/rcvs_queue.sv
// ----------------------------------------------------------------------------
// rcvs_queue
// Result queue: takes up to three beats a cycle, hands out one from the head.
// ----------------------------------------------------------------------------
module rcvs_queue
  import rcvs_pkg::*;
#(
  parameter int unsigned Width = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PushCntW-1:0] push_cnt_i,
  input  logic [Width-1:0]    push_data_i [MaxPush],
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [Width-1:0]    data_o
);

  logic [Width-1:0] q_q [QDepth];
  logic [Width-1:0] q_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d, cnt_pop;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = q_q[0];
  assign pop     = valid_o && ready_i;
  assign cnt_pop = cnt_q - QCntW'(pop);
  // worst case push is three beats
  assign room_o  = (cnt_pop <= QCntW'(QDepth - MaxPush));
  assign cnt_d   = cnt_pop + QCntW'(push_cnt_i);

  always_comb begin
    int unsigned rel;
    for (int unsigned i = 0; i < QDepth; i++) begin
      rel = 0;
      if (pop && i + 1 < QDepth) begin
        q_d[i] = q_q[i+1];
      end else begin
        q_d[i] = q_q[i];
      end
      if (QCntW'(i) >= cnt_pop) begin
        rel = i - int'(cnt_pop);
        if (rel < int'(push_cnt_i)) begin
          q_d[i] = push_data_i[rel[PushCntW-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

FILE: tb/raster_contour_vertex_shift_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raster_contour_vertex_shift_top_tb
// Self-checking bench for the contour vertex shift: it streams closed
// polygons in, predicts every corrected vertex and checks each output beat.
// ----------------------------------------------------------------------------
// Stimulus starts with hand-picked shapes (single and two-vertex polygons,
// squares at the coordinate extremes for both contour settings, diagonal and
// zero-length edges), then random rectilinear polygons mixed with
// free-form noise polygons. Both stream sides idle in random bursts, the
// sink holds off once for a long stretch so the output queue backs up, and
// the final stretch runs with no idling. outer_contour is only written
// between polygons once all results are back.
// ----------------------------------------------------------------------------
module raster_contour_vertex_shift_top_tb;
  import rcvs_pkg::*;

  localparam int CW         = 16;
  localparam int DW         = ((2*CW+7)/8)*8;
  localparam int StallLimit = 1000;   // cycles with no beat on any channel
  localparam int HoldCycles = 80;     // long sink hold-off, fills the queue
  localparam int NumItems   = 120;    // input vertices, directed shapes plus random, in all

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   first_v;
    logic   eop;
    logic   err;
  } shift_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the vertex history and the contour setting,
  // plus the queue of corrected vertices still to come out.
  // --------------------------------------------------------------------------
  class vertex_shift_scoreboard;
    logic          outer_contour = 1'b1;
    coord_t        start_x, start_y, second_x, second_y;
    coord_t        prev_x, prev_y, held_x, held_y;
    seen_e         seen = SEEN_NONE;
    shift_result_t expected_q[$];
    int            mismatches = 0;

    // Side of the edge from (fx,fy) to (tx,ty); mirrored for inner contours
    function side_e side_of(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
      cmp_e  sx, sy;
      side_e s;
      sx = (tx > fx) ? CMP_GT : ((tx < fx) ? CMP_LT : CMP_EQ);
      sy = (ty > fy) ? CMP_GT : ((ty < fy) ? CMP_LT : CMP_EQ);
      s  = SIDE_BAD;
      if (sx == CMP_EQ && sy != CMP_EQ) begin
        s = ((sy == CMP_GT) == outer_contour) ? SIDE_E : SIDE_W;
      end else if (sy == CMP_EQ && sx != CMP_EQ) begin
        s = ((sx == CMP_GT) == outer_contour) ? SIDE_N : SIDE_S;
      end
      return s;
    endfunction

    // Corrected vertex c, given its predecessor p and successor n
    function void predict(coord_t px, coord_t py, coord_t cx, coord_t cy,
                          coord_t nx, coord_t ny, logic is_first);
      side_e         s_in, s_out;
      shift_result_t r;
      s_in      = side_of(px, py, cx, cy);
      s_out     = side_of(cx, cy, nx, ny);
      r.x       = cx;
      r.y       = cy;
      r.first_v = is_first;
      r.eop     = is_first;
      r.err     = (s_in == SIDE_BAD) || (s_out == SIDE_BAD);
      // a side shared by both edges counts once, so OR the two
      if (!r.err) begin
        if (s_in == SIDE_E || s_out == SIDE_E) r.x = r.x - 1'b1;
        if (s_in == SIDE_S || s_out == SIDE_S) r.y = r.y - 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    // Accepted input beat
    function void note_vertex(coord_t vx, coord_t vy, logic last_v);
      if (seen == SEEN_NONE) begin
        start_x = vx;
        start_y = vy;
        if (last_v) predict(vx, vy, vx, vy, vx, vy, 1'b1);
        else        seen = SEEN_ONE;
      end else begin
        if (seen == SEEN_ONE) begin
          second_x = vx;
          second_y = vy;
          prev_x   = start_x;
          prev_y   = start_y;
        end else begin
          predict(prev_x, prev_y, held_x, held_y, vx, vy, 1'b0);
          prev_x = held_x;
          prev_y = held_y;
        end
        held_x = vx;
        held_y = vy;
        seen   = SEEN_MANY;
        if (last_v) begin
          predict(prev_x, prev_y, vx, vy, start_x, start_y, 1'b0);
          predict(vx, vy, start_x, start_y, second_x, second_y, 1'b1);
          seen = SEEN_NONE;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Accepted output beat against the oldest expectation
    task check_result(coord_t x, coord_t y, logic first_v, logic eop, logic err);
      shift_result_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat x=%0d y=%0d", x, y));
        return;
      end
      w = expected_q.pop_front();
      if (x !== w.x) report($sformatf("shifted_x %0d, want %0d", x, w.x));
      if (y !== w.y) report($sformatf("shifted_y %0d, want %0d", y, w.y));
      if (first_v !== w.first_v)
        report($sformatf("is_first_vertex %b, want %b", first_v, w.first_v));
      if (eop !== w.eop) report($sformatf("end_of_polygon %b, want %b", eop, w.eop));
      if (err !== w.err) report($sformatf("edge_error %b, want %b", err, w.err));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          cfg_valid_i   = 1'b0;
  logic          cfg_ready_o;
  logic          cfg_data_i    = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata  = '0;     // [vertex_x, vertex_y] from bit 0
  logic          s_axis_tlast  = 1'b0;   // last_vertex
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;           // [shifted_x, shifted_y] from bit 0
  logic [1:0]    m_axis_tuser;           // [is_first_vertex, edge_error]
  logic          m_axis_tlast;           // end_of_polygon

  raster_contour_vertex_shift_top #(
    .COORD_BITS(CW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  vertex_shift_scoreboard sb = new();

  // bench state
  logic   src_idle_en  = 1'b1;
  logic   sink_idle_en = 1'b1;
  int     hold_request = 0;   // set by the stimulus, taken by the sink
  int     sink_hold    = 0;
  int     sink_gap     = 0;
  int     items_sent   = 0;
  int     stall_cycles = 0;
  coord_t px_q[$];
  coord_t py_q[$];

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sink: tready changes on the falling edge. A pending hold request turns
  // into a long hold-off counted here; otherwise random gap bursts.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      sink_hold    = hold_request;
      hold_request = 0;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready = 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_gap      = $urandom_range(1, 7) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // output beats are checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                      m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
    end
  end

  // watchdog: too long without a beat on any channel ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else if (rst_ni) begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t ns: no beat for %0d cycles", $time, StallLimit);
        $display("raster_contour_vertex_shift_top_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // One vertex beat; entered and left on a falling edge
  task automatic send_vertex(coord_t x, coord_t y, logic last_v);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tdata  = {y, x};
    s_axis_tlast  = last_v;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_vertex(x, y, last_v);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_pt(coord_t x, coord_t y);
    px_q.push_back(x);
    py_q.push_back(y);
  endtask

  // Sends the collected vertices as one polygon, tlast on the final one
  task automatic send_shape();
    int n;
    n = px_q.size();
    for (int i = 0; i < n; i++) send_vertex(px_q[i], py_q[i], i == n - 1);
    px_q.delete();
    py_q.delete();
  endtask

  // Config write, only with nothing in flight; the first vertex of a
  // polygon yields no beat, so let the pipe settle as well
  task automatic write_outer(logic v);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.outer_contour = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Nonzero edge length, mostly short, now and then anything
  function automatic coord_t step_len();
    coord_t d;
    d = ($urandom_range(0, 7) == 0) ? coord_t'($urandom) : coord_t'($urandom_range(1, 60));
    if ($urandom_range(0, 1)) d = -d;
    if (d == 0) d = 1;
    return d;
  endfunction

  // Rectilinear polygon of n (even, >= 4) vertices: edges alternate x and y
  // moves, the last vertex is placed so the closing edge is vertical
  task automatic make_rect(int n);
    coord_t x0, y0, x, y;
    x0 = coord_t'($urandom);
    y0 = coord_t'($urandom);
    x  = x0;
    y  = y0;
    add_pt(x, y);
    for (int i = 1; i <= n - 2; i++) begin
      if (i % 2) x = x + step_len();
      else       y = y + step_len();
      add_pt(x, y);
    end
    add_pt(x0, y);
  endtask

  // Free-form polygon: random points, often sharing a coordinate with the
  // previous one, so aligned, diagonal and zero-length edges all show up
  task automatic make_noise(int n);
    coord_t x, y;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) != 0) x = coord_t'($urandom);
      if ($urandom_range(0, 2) != 0) y = coord_t'($urandom);
      add_pt(x, y);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  pick;
    int  shapes_in_phase;
    logic hold_done;
    shapes_in_phase = 0;
    hold_done       = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, outer contour (reset value)
    add_pt(-32768, -32768);                            // lone vertex, extremes
    send_shape();
    add_pt(32767, 32767);
    send_shape();
    add_pt(-32768, 7);                                 // vertical pair, x wraps
    add_pt(-32768, 100);
    send_shape();
    add_pt(0, 0);                                      // N, E, S, W sides
    add_pt(10, 0);
    add_pt(10, 10);
    add_pt(0, 10);
    send_shape();
    add_pt(-32768, -32768);
    add_pt(32767, -32768);
    add_pt(32767, 32767);
    add_pt(-32768, 32767);
    send_shape();
    add_pt(0, 0);                                      // diagonal edge
    add_pt(5, 5);
    add_pt(0, 5);
    send_shape();
    add_pt(3, 3);                                      // zero-length edge
    add_pt(3, 3);
    add_pt(7, 3);
    send_shape();

    // directed, inner contour: mirrored sides, y wraps at the bottom edge
    write_outer(1'b0);
    add_pt(0, 0);
    add_pt(10, 0);
    add_pt(10, 10);
    add_pt(0, 10);
    send_shape();
    add_pt(-32768, -32768);
    add_pt(32767, -32768);
    add_pt(32767, 32767);
    add_pt(-32768, 32767);
    send_shape();
    write_outer(1'b1);

    // random: mostly well-formed rectilinear polygons, some noise
    while (items_sent < NumItems) begin
      if (items_sent >= NumItems - 30) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (!hold_done && items_sent >= 60) begin
        hold_request = HoldCycles;
        hold_done    = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) make_rect(2 * $urandom_range(2, 5));
      else          make_noise($urandom_range(1, 5));
      send_shape();
      shapes_in_phase++;
      if (shapes_in_phase == 6) begin
        shapes_in_phase = 0;
        write_outer(1'($urandom_range(0, 1)));
      end
    end

    // drain, then settle
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("raster_contour_vertex_shift_top_tb OK");
    end else begin
      $display("raster_contour_vertex_shift_top_tb NOT OK");
    end
    $finish;
  end

endmodule
